>>> rtl/tpsc_pkg.sv
// Shared constants, types and the build-time sine table of the three-phase sine commutator.
`timescale 1ns / 1ps

package tpsc_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int PWM_PERIOD = 1023;
    localparam int MAX_SPEED  = 1000;

    localparam int SPEED_W = 16;
    localparam int DUTY_W  = 10;
    localparam int LIMIT_W = 16;
    localparam int IDX_W   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    localparam int INDEX_B_RESET = TABLE_SIZE / 3;
    localparam int INDEX_C_RESET = 2 * (TABLE_SIZE / 3);

    // The tick divider is MAX_SPEED*360 / (speed*TABLE_SIZE), found one quotient bit a cycle.
    localparam longint DIVIDEND = longint'(MAX_SPEED) * 360;
    localparam int     DVD_W    = $clog2(DIVIDEND + 1);
    localparam int     DVS_W    = SPEED_W + $clog2(TABLE_SIZE + 1);
    localparam int     CNT_W    = $clog2(DVD_W + 1);

    localparam logic [63:0] Q_ONE       = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [DUTY_W-1:0] rom_t [TABLE_SIZE];

    // One Horner step of the Taylor series in Q30; the subtrahend saturates at one.
    function automatic logic [63:0] clip_sub(input logic [63:0] sub);
        return (sub > Q_ONE) ? 64'd0 : (Q_ONE - sub);
    endfunction

    function automatic logic [63:0] sin_poly(input logic [63:0] a2);
        logic [63:0] t;
        t = Q_ONE;
        t = clip_sub(((a2 * t) >> 30) / 64'd272);
        t = clip_sub(((a2 * t) >> 30) / 64'd210);
        t = clip_sub(((a2 * t) >> 30) / 64'd156);
        t = clip_sub(((a2 * t) >> 30) / 64'd110);
        t = clip_sub(((a2 * t) >> 30) / 64'd72);
        t = clip_sub(((a2 * t) >> 30) / 64'd42);
        t = clip_sub(((a2 * t) >> 30) / 64'd20);
        t = clip_sub(((a2 * t) >> 30) / 64'd6);
        return t;
    endfunction

    function automatic logic [63:0] cos_poly(input logic [63:0] a2);
        logic [63:0] t;
        t = Q_ONE;
        t = clip_sub(((a2 * t) >> 30) / 64'd240);
        t = clip_sub(((a2 * t) >> 30) / 64'd182);
        t = clip_sub(((a2 * t) >> 30) / 64'd132);
        t = clip_sub(((a2 * t) >> 30) / 64'd90);
        t = clip_sub(((a2 * t) >> 30) / 64'd56);
        t = clip_sub(((a2 * t) >> 30) / 64'd30);
        t = clip_sub(((a2 * t) >> 30) / 64'd12);
        t = clip_sub(((a2 * t) >> 30) / 64'd2);
        return t;
    endfunction

    // Entry i holds the duty for angle 2*pi*(i+1)/TABLE_SIZE, cut to the duty width.
    function automatic logic [DUTY_W-1:0] rom_entry(input logic [63:0] i);
        logic [63:0] k;
        logic [63:0] q4;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] v;
        logic [63:0] u;
        logic [63:0] e;
        k  = (i + 64'd1) % TABLE_SIZE;
        q4 = 64'd4 * k;
        q  = q4 / TABLE_SIZE;
        r  = q4 - q * 64'(TABLE_SIZE);
        a  = (r * HALF_PI_Q30) / TABLE_SIZE;
        a2 = (a * a) >> 30;
        if (q == 64'd0 || q == 64'd2)
        begin
            v = (a * sin_poly(a2)) >> 30;
        end
        else
        begin
            v = cos_poly(a2);
        end
        if (v > Q_ONE)
        begin
            v = Q_ONE;
        end
        u = (q < 64'd2) ? (Q_ONE + v) : (Q_ONE - v);
        e = (u * 64'(PWM_PERIOD)) >> 31;
        return e[DUTY_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            r[i] = rom_entry(64'(i));
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

endpackage

>>> rtl/three_phase_sine_commutator.sv
// Three-phase sine commutator: tick divider, serial speed divider and sine table look-up.
`timescale 1ns / 1ps

// Each input item is one control tick with a direction and a speed, and it gives exactly
// one result item: the three held duty values and a flag that says whether this tick
// loaded new ones. A tick whose speed is nonzero and differs from the previous speed
// first runs the restoring divider, which finds MAX_SPEED*360 / (speed*TABLE_SIZE) one
// quotient bit per cycle; any other tick skips it. Every tick then waits in the finish
// state for room at the output. The next item is taken while a result still waits at the
// output register, and there is no start-up delay after reset.
module three_phase_sine_commutator
    import tpsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                direction,
    input  logic [SPEED_W-1:0]  speed,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                updated,
    output logic [DUTY_W-1:0]   duty_a,
    output logic [DUTY_W-1:0]   duty_b,
    output logic [DUTY_W-1:0]   duty_c
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t               state_reg,      state_next;
    logic                 dir_reg,        dir_next;
    logic [SPEED_W-1:0]   speed_reg,      speed_next;
    logic [SPEED_W-1:0]   last_speed_reg, last_speed_next;
    logic [LIMIT_W-1:0]   limit_reg,      limit_next;
    logic [LIMIT_W-1:0]   tick_reg,       tick_next;
    logic [IDX_W-1:0]     index_a_reg,    index_a_next;
    logic [IDX_W-1:0]     index_b_reg,    index_b_next;
    logic [IDX_W-1:0]     index_c_reg,    index_c_next;
    logic [DVS_W-1:0]     divisor_reg,    divisor_next;
    logic [DVS_W-1:0]     rem_reg,        rem_next;
    logic [DVD_W-1:0]     quot_reg,       quot_next;
    logic [CNT_W-1:0]     cnt_reg,        cnt_next;
    logic                 out_valid_reg,  out_valid_next;
    logic                 updated_reg,    updated_next;
    logic [DUTY_W-1:0]    duty_a_reg,     duty_a_next;
    logic [DUTY_W-1:0]    duty_b_reg,     duty_b_next;
    logic [DUTY_W-1:0]    duty_c_reg,     duty_c_next;

    logic                 out_free;
    logic [DVS_W:0]       div_shift;
    logic                 div_ge;
    logic [DVS_W-1:0]     div_rem;
    logic [DVD_W-1:0]     div_quot;

    function automatic logic [IDX_W-1:0] step_index(input logic [IDX_W-1:0] idx,
                                                    input logic backward);
        logic [IDX_W-1:0] res;
        if (backward)
        begin
            res = (idx == '0) ? IDX_W'(TABLE_SIZE - 1) : idx - IDX_W'(1);
        end
        else
        begin
            res = (idx == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx + IDX_W'(1);
        end
        return res;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign updated   = updated_reg;
    assign duty_a    = duty_a_reg;
    assign duty_b    = duty_b_reg;
    assign duty_c    = duty_c_reg;

    assign out_free  = !out_valid_reg || out_ready;

    // One restoring step: bring down the next dividend bit and try the subtraction.
    assign div_shift = {rem_reg, quot_reg[DVD_W-1]};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});
    assign div_rem   = div_ge ? DVS_W'(div_shift - {1'b0, divisor_reg})
                              : div_shift[DVS_W-1:0];
    assign div_quot  = {quot_reg[DVD_W-2:0], div_ge};

    always_comb
    begin
        state_next      = state_reg;
        dir_next        = dir_reg;
        speed_next      = speed_reg;
        last_speed_next = last_speed_reg;
        limit_next      = limit_reg;
        tick_next       = tick_reg;
        index_a_next    = index_a_reg;
        index_b_next    = index_b_reg;
        index_c_next    = index_c_reg;
        divisor_next    = divisor_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        updated_next    = updated_reg;
        duty_a_next     = duty_a_reg;
        duty_b_next     = duty_b_reg;
        duty_c_next     = duty_c_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dir_next        = direction;
                    speed_next      = speed;
                    last_speed_next = speed;
                    if (speed != last_speed_reg && speed != '0)
                    begin
                        divisor_next = DVS_W'(speed) * DVS_W'(TABLE_SIZE);
                        rem_next     = '0;
                        quot_next    = DVD_W'(DIVIDEND);
                        cnt_next     = CNT_W'(DVD_W);
                        state_next   = ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_DIVIDE:
            begin
                rem_next  = div_rem;
                quot_next = div_quot;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    // Quotients beyond the limit width saturate.
                    limit_next = (32'(div_quot) > 32'hFFFF) ? '1 : LIMIT_W'(div_quot);
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    updated_next = 1'b0;
                    if (speed_reg != '0)
                    begin
                        if (tick_reg < limit_reg)
                        begin
                            tick_next = tick_reg + LIMIT_W'(1);
                        end
                        else
                        begin
                            tick_next    = '0;
                            duty_a_next  = SINE_ROM[index_a_reg];
                            duty_b_next  = SINE_ROM[index_b_reg];
                            duty_c_next  = SINE_ROM[index_c_reg];
                            index_a_next = step_index(index_a_reg, dir_reg);
                            index_b_next = step_index(index_b_reg, dir_reg);
                            index_c_next = step_index(index_c_reg, dir_reg);
                            updated_next = 1'b1;
                        end
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            dir_reg        <= 1'b0;
            speed_reg      <= '0;
            last_speed_reg <= '0;
            limit_reg      <= '0;
            tick_reg       <= '0;
            index_a_reg    <= '0;
            index_b_reg    <= IDX_W'(INDEX_B_RESET);
            index_c_reg    <= IDX_W'(INDEX_C_RESET);
            divisor_reg    <= '0;
            rem_reg        <= '0;
            quot_reg       <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            updated_reg    <= 1'b0;
            duty_a_reg     <= '0;
            duty_b_reg     <= '0;
            duty_c_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            dir_reg        <= dir_next;
            speed_reg      <= speed_next;
            last_speed_reg <= last_speed_next;
            limit_reg      <= limit_next;
            tick_reg       <= tick_next;
            index_a_reg    <= index_a_next;
            index_b_reg    <= index_b_next;
            index_c_reg    <= index_c_next;
            divisor_reg    <= divisor_next;
            rem_reg        <= rem_next;
            quot_reg       <= quot_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            updated_reg    <= updated_next;
            duty_a_reg     <= duty_a_next;
            duty_b_reg     <= duty_b_next;
            duty_c_reg     <= duty_c_next;
        end
    end

    // An accepted item always moves the sequencer out of idle.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start processing");

    // Finishing with room at the output always presents a result.
    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (out_valid && state_reg == ST_IDLE))
        else $error("finished item gave no result");

    // The phase indices stay TABLE_SIZE/3 entries apart from A to B and from B to C.
    a_spacing_ab: assert property (@(posedge clk) disable iff (!rst_n)
        ((int'(index_b_reg) - int'(index_a_reg) == INDEX_B_RESET) ||
         (int'(index_b_reg) - int'(index_a_reg) == INDEX_B_RESET - TABLE_SIZE)))
        else $error("phase B index lost its spacing from phase A");

    a_spacing_bc: assert property (@(posedge clk) disable iff (!rst_n)
        ((int'(index_c_reg) - int'(index_b_reg) == INDEX_B_RESET) ||
         (int'(index_c_reg) - int'(index_b_reg) == INDEX_B_RESET - TABLE_SIZE)))
        else $error("phase C index lost its spacing from phase B");

endmodule
